// ----- rtl/cdq_pkg.sv -----
// Shared constants and types for the circular deque.
package cdq_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int VALUE_BITS  = 32;
    localparam int CAP_W       = 5;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CW          = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam int IN_BITS     = FUNC_W + VALUE_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STATUS_W + 2 + 2 * VALUE_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [FUNC_W-1:0] OP_POP_REAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic exec;
        logic load;
    } cdq_cmd_t;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// Controller: sequences one item through update, store read and result load.
module cdq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output cdq_pkg::cdq_cmd_t cmd
);
    import cdq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.exec       = 1'b0;
        cmd.load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/cdq_datapath.sv -----
// Datapath: entry store, end indices, count, capacity and result register.
module cdq_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cdq_pkg::cdq_cmd_t              cmd,
    input  logic [cdq_pkg::FUNC_W-1:0]     func,
    input  logic [cdq_pkg::VALUE_BITS-1:0] data_value,
    input  logic                           cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]      cfg_wdata,
    output logic [cdq_pkg::STATUS_W-1:0]   status,
    output logic                           is_empty,
    output logic                           is_full,
    output logic [cdq_pkg::VALUE_BITS-1:0] front_value,
    output logic [cdq_pkg::VALUE_BITS-1:0] rear_value
);
    import cdq_pkg::*;

    logic [VALUE_BITS-1:0] store_mem [STORE_DEPTH];

    logic [CAP_W-1:0]      cap_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      head_next;
    logic [IDX_W-1:0]      tail_reg;
    logic [IDX_W-1:0]      tail_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [STATUS_W-1:0]   st_reg;
    logic [STATUS_W-1:0]   st_next;
    logic [VALUE_BITS-1:0] rd_front_reg;
    logic [VALUE_BITS-1:0] rd_rear_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  empty_reg;
    logic                  full_reg;
    logic [VALUE_BITS-1:0] front_reg;
    logic [VALUE_BITS-1:0] rear_reg;

    logic [CW-1:0]         cap_live;
    logic [IDX_W-1:0]      cap_last;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  cur_empty;
    logic                  cur_full;

    always_comb
    begin
        cap_live = CW'(cap_reg);
        if (cap_live == CW'(0))
            cap_live = CW'(1);
        else if (cap_live > CW'(STORE_DEPTH))
            cap_live = CW'(STORE_DEPTH);
        cap_last = IDX_W'(cap_live - CW'(1));
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        st_next   = ST_DONE;
        wr_en     = 1'b0;
        wr_addr   = '0;
        if ((func == OP_PUSH_FRONT) || (func == OP_PUSH_REAR))
        begin
            if (CW'(cnt_reg) >= cap_live)
            begin
                st_next = ST_OVERFLOW;
            end
            else
            begin
                wr_en = 1'b1;
                if (cnt_reg == '0)
                begin
                    head_next = '0;
                    tail_next = '0;
                    wr_addr   = '0;
                end
                else if (func == OP_PUSH_FRONT)
                begin
                    head_next = (head_reg == '0) ? cap_last : head_reg - IDX_W'(1);
                    wr_addr   = head_next;
                end
                else
                begin
                    tail_next = (CW'(tail_reg) + CW'(1) >= cap_live) ? '0
                                : tail_reg + IDX_W'(1);
                    wr_addr   = tail_next;
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (cnt_reg == '0)
            begin
                st_next = ST_UNDERFLOW;
            end
            else if (cnt_reg == CNT_W'(1))
            begin
                head_next = '0;
                tail_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                if (func == OP_POP_FRONT)
                    head_next = (CW'(head_reg) + CW'(1) >= cap_live) ? '0
                                : head_reg + IDX_W'(1);
                else
                    tail_next = (tail_reg == '0) ? cap_last : tail_reg - IDX_W'(1);
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_W'(STORE_DEPTH);
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg  <= cfg_wdata;
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            store_mem[wr_addr] <= data_value;
        rd_front_reg <= store_mem[head_reg];
        rd_rear_reg  <= store_mem[tail_reg];
        if (cmd.exec)
            st_reg <= st_next;
    end

    assign cur_empty = (cnt_reg == '0);
    assign cur_full  = (CW'(cnt_reg) >= cap_live);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= st_reg;
            empty_reg  <= cur_empty;
            full_reg   <= cur_full;
            front_reg  <= cur_empty ? '0 : rd_front_reg;
            rear_reg   <= cur_empty ? '0 : rd_rear_reg;
        end
    end

    assign status      = status_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;
    assign front_value = front_reg;
    assign rear_value  = rear_reg;

endmodule

// ----- rtl/circular_deque.sv -----
// Circular deque top level: stream ports, controller and datapath.
// Each item is one deque operation and gives one result item. The indices
// and the store write update at acceptance, the store is read at both ends
// through its registered read ports in the next cycle, and the result
// register loads after that once the output side is free. A new item is
// accepted only once the previous result has loaded, so items do not overlap.
// A capacity write empties the deque and must only occur while idle.
module circular_deque
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] func, [33:2] data_value, rest zero
    input  logic [cdq_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [2] is_empty, [3] is_full, [35:4] front_value,
    // [67:36] rear_value, rest zero
    output logic [cdq_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]        cfg_wdata
);
    import cdq_pkg::*;

    cdq_cmd_t              cmd;
    logic [STATUS_W-1:0]   status;
    logic                  is_empty;
    logic                  is_full;
    logic [VALUE_BITS-1:0] front_value;
    logic [VALUE_BITS-1:0] rear_value;

    cdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    cdq_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (s_tdata[FUNC_W-1:0]),
        .data_value  (s_tdata[IN_BITS-1:FUNC_W]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .status      (status),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .front_value (front_value),
        .rear_value  (rear_value)
    );

    always_comb
    begin
        m_tdata                = '0;
        m_tdata[OUT_BITS-1:0]  = {rear_value, front_value, is_full, is_empty, status};
    end

endmodule
